// ===== rtl/core/led_frame_sequencer_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LED_FRAME_SEQUENCER_CORE_DEFINES_SVH
`define LED_FRAME_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFS_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lfs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lfs check failed");

`endif

// ===== rtl/core/lfs_pkg.sv =====
`default_nettype none

package lfs_pkg;

  localparam int LedsPerStrip   = 16;
  localparam int AfterglowSteps = 8;
  localparam int StepCount      = LedsPerStrip + AfterglowSteps;
  localparam int MaxPixels      = (LedsPerStrip < 16) ? LedsPerStrip : 16;

  localparam int StepW    = (StepCount > 1) ? $clog2(StepCount) : 1;
  localparam int IntDepth = StepCount * LedsPerStrip;
  localparam int IntAw    = (IntDepth > 1) ? $clog2(IntDepth) : 1;
  localparam int CntW     = $clog2(MaxPixels + 1);
  localparam int CfgIdxW  = 2;

  localparam logic [StepW-1:0] StepLast = StepW'(StepCount - 1);

  typedef enum logic [1:0] {
    OpTick        = 2'd0,
    OpStart       = 2'd1,
    OpWrDelay     = 2'd2,
    OpWrIntensity = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhWait   = 2'd1,
    PhOutput = 2'd2,
    PhNext   = 2'd3
  } phase_e;

  localparam logic [CfgIdxW-1:0] CfgStripLength = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgStripOffset = CfgIdxW'(1);

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] hue;
    logic [4:0] step_index;
    logic [3:0] led_index;
    logic [7:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [9:0] pixel_address;
    logic [7:0] hue_out;
    logic [7:0] value_out;
    logic       last_pixel;
    logic       running;
    logic [1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [9:0]         wdata;
  } cfg_word_t;

  // Table port requests from the sequencer
  typedef struct packed {
    logic             dly_we;
    logic             dly_re;
    logic [StepW-1:0] dly_waddr;
    logic [StepW-1:0] dly_raddr;
    logic             int_we;
    logic             int_re;
    logic [IntAw-1:0] int_waddr;
    logic [IntAw-1:0] int_raddr;
    logic [7:0]       wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfs_ifs.sv =====
`default_nettype none

interface lfs_in_if import lfs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfs_out_if import lfs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfs_cfg_if import lfs_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfs_tables.sv =====
`default_nettype none

module lfs_tables import lfs_pkg::*; (
  input  logic       clk_i,
  input  tbl_req_t   req_i,
  output logic [7:0] delay_o,
  output logic [7:0] intensity_o
);

  logic [7:0] delay_mem_q     [StepCount];
  logic [7:0] intensity_mem_q [IntDepth];
  logic [7:0] delay_q;
  logic [7:0] intensity_q;

  // Read data holds until the next read of the same table
  always_ff @(posedge clk_i) begin
    if (req_i.dly_we) begin
      delay_mem_q[req_i.dly_waddr] <= req_i.wdata;
    end
    if (req_i.dly_re) begin
      delay_q <= delay_mem_q[req_i.dly_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.int_we) begin
      intensity_mem_q[req_i.int_waddr] <= req_i.wdata;
    end
    if (req_i.int_re) begin
      intensity_q <= intensity_mem_q[req_i.int_raddr];
    end
  end

  assign delay_o     = delay_q;
  assign intensity_o = intensity_q;

endmodule

`default_nettype wire

// ===== rtl/core/lfs_pixel.sv =====
`default_nettype none

module lfs_pixel import lfs_pkg::*; (
  input  logic [7:0]      base_hue_i,
  input  logic [7:0]      intensity_i,
  input  logic [CntW-1:0] led_i,
  input  logic [9:0]      offset_i,
  input  logic            last_i,
  input  phase_e          phase_i,
  output out_item_t       pixel_o
);

  // x / 5 == (x * 205) >> 10 for every 8-bit x
  localparam int RecipFive  = 205;
  localparam int RecipShift = 10;

  logic [7:0]  dim;
  logic [17:0] prod;
  logic [7:0]  hue_step;

  assign dim      = 8'hFF - intensity_i;
  assign prod     = 18'(dim) * 18'(RecipFive);
  assign hue_step = prod[RecipShift +: 8];

  always_comb begin
    pixel_o               = '0;
    pixel_o.pixel_valid   = 1'b1;
    pixel_o.pixel_address = 10'(led_i) + offset_i;
    pixel_o.hue_out       = base_hue_i + hue_step;
    pixel_o.value_out     = intensity_i;
    pixel_o.last_pixel    = last_i;
    pixel_o.running       = (phase_i != PhIdle);
    pixel_o.phase         = phase_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/led_frame_sequencer_core.sv =====
// Channel  | Dir | Word         | Notes
// in_i     | in  | in_item_t    | tick, start, delay write, intensity write
// out_o    | out | out_item_t   | one status word, or one pixel word per LED
// cfg_i    | in  | cfg_word_t   | strip length / strip offset, always ready
//
// A status word is registered and offered in the cycle after its item is taken.
// Start and next-step ticks pass through StLoad to load the wait counter from
// the registered delay read. An output-step tick for n LEDs issues an intensity
// read, then one pixel per cycle while out_o is free, then accepts. rst_ni clears
// control state asynchronously; the tables are not cleared and need no clearing
// pass. When out_o.ready is low, the pending word holds and in_i.ready drops.
`default_nettype none

module led_frame_sequencer_core import lfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lfs_in_if.sink   in_i,
  lfs_out_if.source out_o,
  lfs_cfg_if.sink  cfg_i
);

  // Sequencer states
  localparam logic [1:0] StAccept = 2'd0;
  localparam logic [1:0] StLoad   = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0]       st_q, st_d;
  phase_e           phase_q, phase_d;
  logic [StepW-1:0] step_q, step_d;
  logic [7:0]       wait_q, wait_d;
  logic [7:0]       hue_q, hue_d;
  logic [4:0]       len_q;
  logic [9:0]       offset_q;

  logic [CntW-1:0]  iss_q, iss_d;
  logic             rd_v_q, rd_v_d;
  logic [CntW-1:0]  rd_led_q, rd_led_d;
  logic             rd_last_q, rd_last_d;

  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  tbl_req_t         req;
  logic [7:0]       dly_rdata;
  logic [7:0]       int_rdata;
  out_item_t        pixel;

  logic             out_free;
  logic             in_fire;
  logic             cfg_fire;
  logic             status_load;
  logic             issue;
  logic             move;
  logic             step_ok;
  logic             led_ok;
  logic [7:0]       wait_dec;
  logic [CntW-1:0]  npix;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (st_q == StAccept) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire   = cfg_i.valid;

  assign step_ok  = int'(in_i.data.step_index) < StepCount;
  assign led_ok   = int'(in_i.data.led_index) < LedsPerStrip;
  assign wait_dec = (wait_q != 8'd0) ? wait_q - 8'd1 : wait_q;
  // Saturate the strip length to the LEDs the table holds
  assign npix     = (int'(len_q) > MaxPixels) ? CntW'(MaxPixels) : CntW'(len_q);

  // Issue the next intensity read when the read stage is empty or drains now
  assign move  = rd_v_q && out_free;
  assign issue = (st_q == StEmit) && (iss_q != npix) && (!rd_v_q || move);

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    step_d      = step_q;
    wait_d      = wait_q;
    hue_d       = hue_q;
    iss_d       = iss_q;
    rd_v_d      = rd_v_q;
    rd_led_d    = rd_led_q;
    rd_last_d   = rd_last_q;
    status_load = 1'b0;

    req           = '0;
    req.wdata     = in_i.data.table_value;
    req.dly_waddr = StepW'(in_i.data.step_index);
    req.int_waddr = IntAw'(int'(in_i.data.step_index) * LedsPerStrip
                           + int'(in_i.data.led_index));
    req.int_raddr = IntAw'(int'(step_q) * LedsPerStrip + int'(iss_q));

    if (in_fire) begin
      status_load = 1'b1;
      unique case (opcode_e'(in_i.data.opcode))
        OpWrDelay: begin
          req.dly_we = step_ok;
        end
        OpWrIntensity: begin
          req.int_we = step_ok && led_ok;
        end
        OpStart: begin
          // Ignore a start while a run is in progress
          if (phase_q == PhIdle) begin
            phase_d       = PhWait;
            step_d        = '0;
            hue_d         = in_i.data.hue;
            req.dly_re    = 1'b1;
            req.dly_raddr = '0;
            st_d          = StLoad;
          end
        end
        OpTick: begin
          unique case (phase_q)
            PhIdle: begin
            end
            PhWait: begin
              wait_d = wait_dec;
              if (wait_dec == 8'd0) begin
                phase_d = PhOutput;
              end
            end
            PhOutput: begin
              phase_d = PhNext;
              // Empty strip: the status word stands in for the pixels
              if (npix != '0) begin
                status_load = 1'b0;
                iss_d       = '0;
                st_d        = StEmit;
              end
            end
            PhNext: begin
              if (step_q < StepLast) begin
                phase_d       = PhWait;
                step_d        = step_q + StepW'(1);
                req.dly_re    = 1'b1;
                req.dly_raddr = step_q + StepW'(1);
                st_d          = StLoad;
              end else begin
                phase_d = PhIdle;
                step_d  = '0;
              end
            end
          endcase
        end
      endcase
    end

    // Load the wait counter from the delay read issued last cycle
    if (st_q == StLoad) begin
      wait_d = dly_rdata;
      st_d   = StAccept;
    end

    if (issue) begin
      req.int_re = 1'b1;
      iss_d      = iss_q + CntW'(1);
      rd_led_d   = iss_q;
      rd_last_d  = (iss_q + CntW'(1) == npix);
    end

    if (issue) begin
      rd_v_d = 1'b1;
    end else if (move) begin
      rd_v_d = 1'b0;
    end

    if (move && rd_last_q) begin
      st_d  = StAccept;
      iss_d = '0;
    end
  end

  // Output word register
  always_comb begin
    out_d = out_q;
    if (status_load) begin
      out_d            = '0;
      out_d.last_pixel = 1'b1;
      out_d.running    = (phase_d != PhIdle);
      out_d.phase      = phase_d;
    end else if (move) begin
      out_d = pixel;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (status_load || move) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StAccept;
      phase_q     <= PhIdle;
      step_q      <= '0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      iss_q       <= iss_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= 5'd16;
      offset_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_i.data.index)
        CfgStripLength: len_q    <= cfg_i.data.wdata[4:0];
        CfgStripOffset: offset_q <= cfg_i.data.wdata;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wait_q    <= wait_d;
    hue_q     <= hue_d;
    rd_led_q  <= rd_led_d;
    rd_last_q <= rd_last_d;
    out_q     <= out_d;
  end

  lfs_tables u_tables (
    .clk_i       (clk_i),
    .req_i       (req),
    .delay_o     (dly_rdata),
    .intensity_o (int_rdata)
  );

  lfs_pixel u_pixel (
    .base_hue_i  (hue_q),
    .intensity_i (int_rdata),
    .led_i       (rd_led_q),
    .offset_i    (offset_q),
    .last_i      (rd_last_q),
    .phase_i     (phase_q),
    .pixel_o     (pixel)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lfs_checker.sv =====
`default_nettype none
`include "led_frame_sequencer_core_defines.svh"

module lfs_checker import lfs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  `LFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `LFS_ASSERT_NOW(a_pixel_phase, clk_i, rst_ni, out_valid_i && out_data_i.pixel_valid, out_data_i.running && (out_data_i.phase == PhNext))
  `LFS_ASSERT_NOW(a_status_blank, clk_i, rst_ni, out_valid_i && !out_data_i.pixel_valid, out_data_i.last_pixel && (out_data_i.hue_out == 8'd0) && (out_data_i.value_out == 8'd0) && (out_data_i.pixel_address == 10'd0))
  `LFS_ASSERT_NOW(a_run_flag, clk_i, rst_ni, out_valid_i, out_data_i.running == (out_data_i.phase != PhIdle))

endmodule

bind led_frame_sequencer_core lfs_checker u_lfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// ===== tb/tb_led_frame_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_led_frame_sequencer_core;
  import lfs_pkg::*;

  // Control state of one animation run; tables live beside it.
  typedef struct packed {
    phase_e           ph;
    logic             active;
    logic [StepW-1:0] step;
    logic [7:0]       wait_cnt;
    logic [7:0]       base;
  } run_ctl_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfs_in_if  in_if ();
  lfs_out_if out_if ();
  lfs_cfg_if cfg_if ();

  led_frame_sequencer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Checker copy of the block: tables, run control and registers.
  logic [7:0] delay_tbl [StepCount];
  logic [7:0] level_tbl [StepCount][LedsPerStrip];
  run_ctl_t   chk_ctl;
  logic [4:0] cfg_len;
  logic [9:0] cfg_off;

  // Stimulus-side shadow: only what is needed to shape well-formed runs.
  logic [7:0] gen_delay [StepCount];
  run_ctl_t   gen_ctl;

  in_item_t  pending_items[$];
  out_item_t expected_words[$];

  int queued_cnt, taken_cnt, out_cnt, pixel_cnt, status_cnt;
  int run_cnt, reg_cnt, err_cnt, rand_cnt, seg_idx;

  // Handshake flags sampled at the rising edge, used at the falling edge.
  logic in_fire, out_fire;
  int   tx_gap, rx_gap, hold_cnt;
  logic tx_burst, rx_burst, hold_done;

  // Register settings walked through between segments, extremes first.
  int len_set [8] = '{16, 1, 0, 31, 5, 16, 12, 17};
  int off_set [8] = '{1008, 0, 1023, 500, 3, 1017, 0, 64};

  // Advance run control by one word; caller passes delay entry 0 and the
  // entry of the following step.
  function automatic run_ctl_t ctrl_next(input run_ctl_t c, input in_item_t it,
                                         input logic [7:0] dly0,
                                         input logic [7:0] dly_nxt);
    if (it.opcode == OpStart) begin
      // drop a start that lands in the middle of a run
      if (!c.active) begin
        c.active   = 1'b1;
        c.step     = '0;
        c.wait_cnt = dly0;
        c.base     = it.hue;
        c.ph       = PhWait;
      end
    end else if (it.opcode == OpTick) begin
      case (c.ph)
        PhWait: begin
          if (c.wait_cnt != 8'd0) c.wait_cnt = c.wait_cnt - 8'd1;
          if (c.wait_cnt == 8'd0) c.ph = PhOutput;
        end
        PhOutput: c.ph = PhNext;
        PhNext: begin
          if (c.step < StepLast) begin
            c.ph       = PhWait;
            c.step     = c.step + 1'b1;
            c.wait_cnt = dly_nxt;
          end else begin
            c.ph       = PhIdle;
            c.active   = 1'b0;
            c.step     = '0;
            c.wait_cnt = dly0;
          end
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // Work out the words one accepted item causes and queue them.
  task automatic predict_words(input in_item_t it);
    out_item_t  w;
    logic [7:0] nxt, v;
    int         n;
    logic       was_active;
    if (it.opcode == OpWrDelay && it.step_index < StepCount)
      delay_tbl[it.step_index] = it.table_value;
    if (it.opcode == OpWrIntensity && it.step_index < StepCount)
      level_tbl[it.step_index][it.led_index] = it.table_value;
    n = 0;
    if (it.opcode == OpTick && chk_ctl.ph == PhOutput)
      n = (cfg_len > MaxPixels) ? MaxPixels : int'(cfg_len);
    nxt = (chk_ctl.step < StepLast) ? delay_tbl[chk_ctl.step + 1'b1] : 8'h00;
    was_active = chk_ctl.active;
    chk_ctl = ctrl_next(chk_ctl, it, delay_tbl[0], nxt);
    if (was_active && !chk_ctl.active) run_cnt++;
    w.running = chk_ctl.active;
    w.phase   = chk_ctl.ph;
    if (n == 0) begin
      // status word, also stands in for an empty output step
      w.pixel_valid   = 1'b0;
      w.pixel_address = '0;
      w.hue_out       = '0;
      w.value_out     = '0;
      w.last_pixel    = 1'b1;
      expected_words.push_back(w);
    end else begin
      for (int led = 0; led < n; led++) begin
        v = level_tbl[chk_ctl.step][led];
        w.pixel_valid   = 1'b1;
        w.pixel_address = 10'(led) + cfg_off;
        w.hue_out       = chk_ctl.base + 8'((8'd255 - v) / 8'd5);
        w.value_out     = v;
        w.last_pixel    = (led + 1 == n);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [9:0] exp_v,
                                 input logic [9:0] got_v);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch on output word %0d: %s expected %0h got %0h",
               out_cnt, what, exp_v, got_v);
  endtask

  // Acceptance and checking: inputs first, so a word is predicted before
  // anything it causes can show up.
  always @(posedge clk_i) begin : monitor
    out_item_t w;
    in_fire  = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    if (in_fire) begin
      predict_words(in_if.data);
      taken_cnt++;
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      reg_cnt++;
      case (cfg_if.data.index)
        CfgStripLength: cfg_len = cfg_if.data.wdata[4:0];
        CfgStripOffset: cfg_off = cfg_if.data.wdata;
        default: ;
      endcase
    end
    if (out_fire) begin
      out_cnt++;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", '0, '0);
      end else begin
        w = expected_words.pop_front();
        if (w.pixel_valid) pixel_cnt++;
        else status_cnt++;
        if (out_if.data.pixel_valid !== w.pixel_valid)
          report_mismatch("pixel_valid", w.pixel_valid, out_if.data.pixel_valid);
        if (out_if.data.pixel_address !== w.pixel_address)
          report_mismatch("pixel_address", w.pixel_address, out_if.data.pixel_address);
        if (out_if.data.hue_out !== w.hue_out)
          report_mismatch("hue_out", w.hue_out, out_if.data.hue_out);
        if (out_if.data.value_out !== w.value_out)
          report_mismatch("value_out", w.value_out, out_if.data.value_out);
        if (out_if.data.last_pixel !== w.last_pixel)
          report_mismatch("last_pixel", w.last_pixel, out_if.data.last_pixel);
        if (out_if.data.running !== w.running)
          report_mismatch("running", w.running, out_if.data.running);
        if (out_if.data.phase !== w.phase)
          report_mismatch("phase", w.phase, out_if.data.phase);
      end
    end
  end

  // Input driver: hold a word until taken, then idle with valid low for the drawn
  // gap and present the next one; valid stays high only when the gap is zero.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_if.data  <= pending_items.pop_front();
          in_if.valid <= 1'b1;
          if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 8);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output receiver: stall a drawn number of cycles after each word, and
  // once hold off for a long stretch so the block backs up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_fire) begin
        if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 8);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && out_cnt >= 100) begin
        hold_done = 1'b1;
        hold_cnt  = 400;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [7:0] hue,
                                  input logic [4:0] step, input logic [3:0] led,
                                  input logic [7:0] val);
    in_item_t it;
    it.opcode      = op;
    it.hue         = hue;
    it.step_index  = step;
    it.led_index   = led;
    it.table_value = val;
    return it;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] op);
    return mk(op, 8'($urandom), 5'($urandom), 4'($urandom), 8'($urandom));
  endfunction

  // Mostly short waits, some zero, a rare long one.
  function automatic logic [7:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'd0;
    if (r < 97) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(4, 255));
  endfunction

  // Queue one word and advance the stimulus shadow with it.
  task automatic queue_word(input in_item_t it);
    logic [7:0] nxt;
    if (it.opcode == OpWrDelay && it.step_index < StepCount)
      gen_delay[it.step_index] = it.table_value;
    nxt = (gen_ctl.step < StepLast) ? gen_delay[gen_ctl.step + 1'b1] : 8'h00;
    gen_ctl = ctrl_next(gen_ctl, it, gen_delay[0], nxt);
    pending_items.push_back(it);
    queued_cnt++;
  endtask

  // Table write with an in-range step most of the time.
  task automatic queue_table_write(input logic [1:0] op);
    in_item_t it;
    it = rand_item(op);
    if ($urandom_range(0, 9) != 0) it.step_index = 5'($urandom_range(0, StepCount - 1));
    if (op == OpWrDelay) it.table_value = pick_delay();
    queue_word(it);
  endtask

  // Random segment: mostly starts and ticks that drive runs to the end,
  // mixed with table rewrites, ignored starts and ticks while idle.
  task automatic queue_segment(input int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (!gen_ctl.active) begin
        if (r < 40) queue_word(rand_item(OpStart));
        else if (r < 60) queue_word(rand_item(OpTick));
        else if (r < 80) queue_table_write(OpWrDelay);
        else queue_table_write(OpWrIntensity);
      end else begin
        if (r < 82) queue_word(rand_item(OpTick));
        else if (r < 88) queue_word(rand_item(OpStart));
        else if (r < 94) queue_table_write(OpWrDelay);
        else queue_table_write(OpWrIntensity);
      end
    end
  endtask

  // Wait until every queued word is taken and every expected word is back.
  task automatic wait_idle();
    while (taken_cnt != queued_cnt || expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [9:0] val);
    @(negedge clk_i);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    chk_ctl = '0;
    chk_ctl.ph = PhIdle;
    gen_ctl = chk_ctl;
    cfg_len = 5'd16;
    cfg_off = 10'd0;
    tx_gap = 0; rx_gap = 0; hold_cnt = 0;
    tx_burst = 1'b0; rx_burst = 1'b0; hold_done = 1'b0;
    in_fire = 1'b0; out_fire = 1'b0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every table entry before any run can read one.
    for (int s = 0; s < StepCount; s++) begin
      in_item_t it;
      it = rand_item(OpWrDelay);
      it.step_index  = 5'(s);
      it.table_value = pick_delay();
      queue_word(it);
    end
    for (int s = 0; s < StepCount; s++) begin
      for (int l = 0; l < LedsPerStrip; l++) begin
        in_item_t it;
        it = rand_item(OpWrIntensity);
        it.step_index = 5'(s);
        it.led_index  = 4'(l);
        queue_word(it);
      end
    end

    // Directed: idle ticks, ignored writes, extreme bytes, zero delay,
    // a start at full hue, starts while running, and an output step.
    queue_word(mk(OpTick, 8'h00, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpTick, 8'hff, 5'd31, 4'd15, 8'hff));
    queue_word(mk(OpWrDelay, 8'h00, 5'd24, 4'd0, 8'hff));
    queue_word(mk(OpWrDelay, 8'hff, 5'd31, 4'd15, 8'h00));
    queue_word(mk(OpWrIntensity, 8'h00, 5'd24, 4'd3, 8'h55));
    queue_word(mk(OpWrIntensity, 8'hff, 5'd31, 4'd15, 8'hff));
    queue_word(mk(OpWrIntensity, 8'h00, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpWrIntensity, 8'h00, 5'd0, 4'd15, 8'hff));
    queue_word(mk(OpWrIntensity, 8'h00, 5'd23, 4'd15, 8'hff));
    queue_word(mk(OpWrDelay, 8'h00, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpWrDelay, 8'h00, 5'd1, 4'd0, 8'hff));
    queue_word(mk(OpWrDelay, 8'h00, 5'd23, 4'd0, 8'h01));
    queue_word(mk(OpStart, 8'hff, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpStart, 8'h00, 5'd31, 4'd15, 8'hff));
    queue_word(mk(OpTick, 8'h00, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpTick, 8'h00, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpStart, 8'h7f, 5'd0, 4'd0, 8'h00));
    queue_word(mk(OpTick, 8'h00, 5'd0, 4'd0, 8'h00));
    wait_idle();

    // Random segments; change registers only while nothing is in flight.
    rand_cnt = 0;
    seg_idx  = 0;
    while (rand_cnt < 360) begin
      int seg;
      seg = $urandom_range(25, 50);
      queue_segment(seg);
      rand_cnt += seg;
      wait_idle();
      if (seg_idx < 8) begin
        write_reg(CfgStripLength, 10'(len_set[seg_idx]));
        write_reg(CfgStripOffset, 10'(off_set[seg_idx]));
      end else begin
        write_reg(CfgStripLength,
                  ($urandom_range(0, 3) == 0) ? 10'd16 : 10'($urandom_range(0, 31)));
        write_reg(CfgStripOffset, 10'($urandom));
      end
      seg_idx++;
    end

    // Finish the run in progress so the return to idle is seen again.
    while (gen_ctl.active) queue_word(rand_item(OpTick));
    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("covered %0d input words: %0d pixel and %0d status words checked",
             taken_cnt, pixel_cnt, status_cnt);
    $display("%0d runs played to the end, %0d register writes, %0d mismatches",
             run_cnt, reg_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== led_frame_sequencer_core.f =====
+incdir+rtl/core
rtl/core/lfs_pkg.sv
rtl/core/lfs_ifs.sv
rtl/core/lfs_tables.sv
rtl/core/lfs_pixel.sv
rtl/core/led_frame_sequencer_core.sv
rtl/core/lfs_checker.sv
tb/tb_led_frame_sequencer_core.sv
